>>> rtl/rotenc_pkg.sv
// ---------------------------------------------------------------------------
// rotenc_pkg
// shared types and constants of the rotary encoder clamped counter
// ---------------------------------------------------------------------------
package rotenc_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned PhaseWidth = 2;

   // configuration register indexes
   localparam logic CSR_LOWER_LIMIT = 1'b0;
   localparam logic CSR_UPPER_LIMIT = 1'b1;

   // item packing
   localparam int unsigned ReqDataWidth = 8;   // encoder_ab, switch_level, pad
   localparam int unsigned RspDataWidth = 24;  // count, toggle_flag, pad

   // step codes remembered between samples
   typedef enum logic [1:0] {
      STEP_NONE = 2'b00,
      STEP_UP   = 2'b01,
      STEP_DOWN = 2'b11
   } step_type;

   // transition index {prev_phase, current_phase}
   localparam logic [3:0] TRANS_UP_RISE   = 4'b0001;
   localparam logic [3:0] TRANS_UP_FALL   = 4'b1110;
   localparam logic [3:0] TRANS_DOWN_RISE = 4'b1011;
   localparam logic [3:0] TRANS_DOWN_FALL = 4'b0100;
   localparam logic [3:0] TRANS_SKIP_A    = 4'b0011;
   localparam logic [3:0] TRANS_SKIP_B    = 4'b0110;
   localparam logic [3:0] TRANS_SKIP_C    = 4'b1001;
   localparam logic [3:0] TRANS_SKIP_D    = 4'b1100;

   typedef logic signed [CountWidth-1:0] count_type;

endpackage

>>> rtl/rotary_encoder_clamped_counter.sv
// ---------------------------------------------------------------------------
// rotary_encoder_clamped_counter
// quadrature knob decoder with clamped position and push-switch toggle
// ---------------------------------------------------------------------------
// usage
//   req channel: one item per pin sample, encoder phase pair and switch level
//   rsp channel: one item per sample, clamped knob count and toggle flag
//   csr port: write-only lower and upper limit, 16 bit signed each; write
//     only while no item is in flight, new limits apply from the next sample
// latency: an accepted item sits one cycle in the input register, the
//   decode, step add and clamp run in that cycle, and the result appears
//   in the output register on the following edge: rsp_tvalid rises one
//   cycle after the item is taken
// throughput: one item per clock; the single-cycle update of the position
//   register (add and two signed compares) sets that figure
// stall: while rsp_tready is low the result register holds; one more item
//   is still taken into the input register, then req_tready drops until
//   the result is taken
// reset: synchronous, clears both stages, the phase, step, switch and
//   position state, and loads the limits 0 and 8
// crossed limits (lower above upper) give the lower limit
// ---------------------------------------------------------------------------
module rotary_encoder_clamped_counter (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [1:0] encoder_ab, [2] switch_level, [7:3] zero
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rotenc_pkg::ReqDataWidth-1:0]   req_tdata,
   // rsp_tdata: [15:0] count, [16] toggle_flag, [23:17] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rotenc_pkg::RspDataWidth-1:0]   rsp_tdata,
   // configuration write port
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [rotenc_pkg::CountWidth-1:0]     csr_wdata
);
   import rotenc_pkg::*;

   // input stage
   logic                  in_valid_ff;
   logic [PhaseWidth-1:0] in_ab_ff;
   logic                  in_sw_ff;

   // decoder state
   logic [PhaseWidth-1:0] prev_phase_ff;
   step_type              last_step_ff;
   count_type             position_ff;
   logic                  prev_switch_ff;
   logic                  toggle_ff;

   // limits
   count_type             lower_ff;
   count_type             upper_ff;

   // output stage
   logic                  out_valid_ff;

   // next values
   step_type              step_in;
   count_type             position_in;
   logic                  toggle_in;
   logic                  advance;
   logic [3:0]            trans_idx;
   logic signed [CountWidth:0] sum;
   logic signed [CountWidth:0] upper_ext;
   logic signed [CountWidth:0] lower_ext;
   logic signed [CountWidth:0] capped;

   // the input item moves on when the result register is free or being taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // transition decode
   assign trans_idx = {prev_phase_ff, in_ab_ff};

   always_comb begin
      unique case (trans_idx)
         TRANS_UP_RISE, TRANS_UP_FALL: begin
            step_in = STEP_UP;
         end
         TRANS_DOWN_RISE, TRANS_DOWN_FALL: begin
            step_in = STEP_DOWN;
         end
         TRANS_SKIP_A, TRANS_SKIP_B, TRANS_SKIP_C, TRANS_SKIP_D: begin
            // a skipped state keeps turning the same way
            step_in = last_step_ff;
         end
         default: begin
            step_in = STEP_NONE;
         end
      endcase
   end

   // step add one bit wider so it cannot wrap, then min against upper,
   // max against lower (lower wins on crossed limits)
   always_comb begin
      upper_ext = {upper_ff[CountWidth-1], upper_ff};
      lower_ext = {lower_ff[CountWidth-1], lower_ff};
      unique case (step_in)
         STEP_UP:   sum = {position_ff[CountWidth-1], position_ff} + 17'sd1;
         STEP_DOWN: sum = {position_ff[CountWidth-1], position_ff} - 17'sd1;
         default:   sum = {position_ff[CountWidth-1], position_ff};
      endcase
      capped      = (sum > upper_ext) ? upper_ext : sum;
      capped      = (capped < lower_ext) ? lower_ext : capped;
      position_in = capped[CountWidth-1:0];
   end

   // switch release flips the flag
   assign toggle_in = toggle_ff ^ (prev_switch_ff & ~in_sw_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_ab_ff <= req_tdata[PhaseWidth-1:0];
         in_sw_ff <= req_tdata[PhaseWidth];
      end
   end

   // decoder state, updated as each item passes into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff  <= '0;
         last_step_ff   <= STEP_NONE;
         position_ff    <= '0;
         prev_switch_ff <= 1'b0;
         toggle_ff      <= 1'b0;
      end else if (advance) begin
         prev_phase_ff  <= in_ab_ff;
         last_step_ff   <= step_in;
         position_ff    <= position_in;
         prev_switch_ff <= in_sw_ff;
         toggle_ff      <= toggle_in;
      end
   end

   // result register: valid only, payload comes from the state just written
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= 16'sd0;
         upper_ff <= 16'sd8;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOWER_LIMIT: lower_ff <= csr_wdata;
            CSR_UPPER_LIMIT: upper_ff <= csr_wdata;
            default:         lower_ff <= lower_ff;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - CountWidth - 1){1'b0}}, toggle_ff, position_ff};

   // a passing item always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("result register empty after an item passed");

   // with ordered limits every result lies inside them
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (lower_ff <= upper_ff)) |->
         ((position_ff >= lower_ff) && (position_ff <= upper_ff)))
      else $error("count outside limits");

   // the toggle flag only moves when an item passes
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(advance)) |-> $stable(toggle_ff))
      else $error("toggle flag changed without an item");

endmodule
